### sv/chb_pkg.sv
// Shared types, codes and helpers for the chunked body decoder.
`default_nettype none

package chb_pkg;

    localparam int SIZE_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int CFG_W          = 32;
    localparam int TOTAL_W        = 32;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int M_TDATA_W      = 48;

    localparam logic [CFG_W-1:0]  MAX_BODY_RST = 32'd1048576;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0a;

    typedef enum logic [8:0] {
        PH_SIZE_FIRST = 9'b000000001,
        PH_SIZE_MORE  = 9'b000000010,
        PH_SIZE_LF    = 9'b000000100,
        PH_DATA       = 9'b000001000,
        PH_DATA_CR    = 9'b000010000,
        PH_DATA_LF    = 9'b000100000,
        PH_LAST_CR    = 9'b001000000,
        PH_LAST_LF    = 9'b010000000,
        PH_DONE       = 9'b100000000
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY  = 3'd0,
        ST_DONE  = 3'd1,
        ST_BAD   = 3'd2,
        ST_BIG   = 3'd3,
        ST_AFTER = 3'd4
    } status_t;

    // One result word as produced by the step logic.
    typedef struct packed {
        logic                   payload_valid;
        logic [BYTE_W-1:0]      payload_byte;
        status_t                status;
        logic [TOTAL_W-1:0]     data_total;
    } result_t;

    // Bit 4 set when the byte is a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/chb_step.sv
// Next-state and result logic for one received byte.
`default_nettype none

module chb_step #(
    parameter int SIZE_BITS  = chb_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = chb_pkg::COUNT_BITS_DEF
) (
    input  wire logic [chb_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       message_start,
    input  wire logic [chb_pkg::CFG_W-1:0]  max_body_size,
    input  chb_pkg::phase_t                 phase,
    input  wire logic [SIZE_BITS-1:0]       chunk_size_acc,
    input  wire logic [SIZE_BITS-1:0]       data_left,
    input  wire logic [COUNT_BITS-1:0]      wire_count,
    input  wire logic [COUNT_BITS-1:0]      payload_total,
    input  chb_pkg::status_t                status,
    output chb_pkg::phase_t                 phase_next,
    output logic [SIZE_BITS-1:0]            chunk_size_acc_next,
    output logic [SIZE_BITS-1:0]            data_left_next,
    output logic [COUNT_BITS-1:0]           wire_count_next,
    output logic [COUNT_BITS-1:0]           payload_total_next,
    output chb_pkg::status_t                status_next,
    output chb_pkg::result_t                result
);

    localparam int CMP_W = (COUNT_BITS > chb_pkg::CFG_W) ? COUNT_BITS : chb_pkg::CFG_W;

    chb_pkg::phase_t         ph;
    chb_pkg::status_t        st;
    logic [SIZE_BITS-1:0]    acc;
    logic [SIZE_BITS-1:0]    dl;
    logic [SIZE_BITS-1:0]    acc_shift;
    logic [SIZE_BITS-1:0]    dl_dec;
    logic [COUNT_BITS-1:0]   wc;
    logic [COUNT_BITS-1:0]   wc_inc;
    logic [COUNT_BITS-1:0]   pt;
    logic [4:0]              hex;
    logic                    size_ovf;
    logic                    pv;
    logic [chb_pkg::TOTAL_W-1:0] total_sat;

    always_comb begin
        // A new body starts from the reset state before this byte.
        ph  = message_start ? chb_pkg::PH_SIZE_FIRST : phase;
        st  = message_start ? chb_pkg::ST_BUSY : status;
        acc = message_start ? '0 : chunk_size_acc;
        dl  = message_start ? '0 : data_left;
        wc  = message_start ? '0 : wire_count;
        pt  = message_start ? '0 : payload_total;

        hex       = chb_pkg::hex_value(data_byte);
        acc_shift = {acc[SIZE_BITS-5:0], hex[3:0]};
        size_ovf  = (|acc[SIZE_BITS-1:SIZE_BITS-4]) || (acc_shift == '1);
        wc_inc    = (wc != '1) ? wc + COUNT_BITS'(1) : wc;
        dl_dec    = (dl != '0) ? dl - SIZE_BITS'(1) : dl;

        phase_next          = ph;
        status_next         = st;
        chunk_size_acc_next = acc;
        data_left_next      = dl;
        wire_count_next     = wc;
        payload_total_next  = pt;
        pv                  = 1'b0;

        case (st)
            chb_pkg::ST_DONE: begin
                status_next = chb_pkg::ST_AFTER;
            end
            chb_pkg::ST_BUSY: begin
                wire_count_next = wc_inc;
                if (CMP_W'(wc_inc) > CMP_W'(max_body_size)) begin
                    status_next = chb_pkg::ST_BIG;
                end else begin
                    case (ph)
                        chb_pkg::PH_SIZE_FIRST,
                        chb_pkg::PH_SIZE_MORE: begin
                            if (hex[4]) begin
                                if (size_ovf) begin
                                    status_next = chb_pkg::ST_BAD;
                                end else begin
                                    chunk_size_acc_next = acc_shift;
                                    phase_next          = chb_pkg::PH_SIZE_MORE;
                                end
                            end else if (data_byte == chb_pkg::CH_CR &&
                                         ph == chb_pkg::PH_SIZE_MORE) begin
                                phase_next = chb_pkg::PH_SIZE_LF;
                            end else begin
                                status_next = chb_pkg::ST_BAD;
                            end
                        end
                        chb_pkg::PH_SIZE_LF: begin
                            if (data_byte != chb_pkg::CH_LF) begin
                                status_next = chb_pkg::ST_BAD;
                            end else begin
                                if (acc == '0) begin
                                    phase_next = chb_pkg::PH_LAST_CR;
                                end else begin
                                    data_left_next = acc;
                                    phase_next     = chb_pkg::PH_DATA;
                                end
                                chunk_size_acc_next = '0;
                            end
                        end
                        chb_pkg::PH_DATA: begin
                            pv                 = 1'b1;
                            payload_total_next = (pt != '1) ? pt + COUNT_BITS'(1) : pt;
                            data_left_next     = dl_dec;
                            if (dl_dec == '0) begin
                                phase_next = chb_pkg::PH_DATA_CR;
                            end
                        end
                        chb_pkg::PH_DATA_CR: begin
                            if (data_byte == chb_pkg::CH_CR) phase_next = chb_pkg::PH_DATA_LF;
                            else status_next = chb_pkg::ST_BAD;
                        end
                        chb_pkg::PH_DATA_LF: begin
                            if (data_byte == chb_pkg::CH_LF) phase_next = chb_pkg::PH_SIZE_FIRST;
                            else status_next = chb_pkg::ST_BAD;
                        end
                        chb_pkg::PH_LAST_CR: begin
                            if (data_byte == chb_pkg::CH_CR) phase_next = chb_pkg::PH_LAST_LF;
                            else status_next = chb_pkg::ST_BAD;
                        end
                        chb_pkg::PH_LAST_LF: begin
                            if (data_byte == chb_pkg::CH_LF) begin
                                phase_next  = chb_pkg::PH_DONE;
                                status_next = chb_pkg::ST_DONE;
                            end else begin
                                status_next = chb_pkg::ST_BAD;
                            end
                        end
                        default: begin
                            status_next = chb_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            default: begin
                // error codes hold until a new body starts
            end
        endcase
    end

    generate
        if (COUNT_BITS > chb_pkg::TOTAL_W) begin : g_sat
            assign total_sat = (|payload_total_next[COUNT_BITS-1:chb_pkg::TOTAL_W]) ?
                               '1 : payload_total_next[chb_pkg::TOTAL_W-1:0];
        end else begin : g_ext
            assign total_sat = chb_pkg::TOTAL_W'(payload_total_next);
        end
    endgenerate

    assign result.payload_valid = pv;
    assign result.payload_byte  = pv ? data_byte : '0;
    assign result.status        = status_next;
    assign result.data_total    = total_sat;

endmodule

`default_nettype wire

### sv/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder.
//
// Channels:
//   s_*   : one received body byte per word. s_tdata holds data_byte,
//           s_tuser[0] is message_start (clears decoder state before the byte).
//   m_*   : one result word per input word. m_tuser[0] is payload_valid,
//           m_tdata holds payload_byte, status and data_total.
//   cfg_* : write of max_body_size; always ready, takes effect at once.
// Throughput: one byte per cycle sustained while m_tready stays high. The chunk
// state loop (phase, size accumulator, counters) closes through chb_step.
// Path: an accepted byte moves from the input register to the result register,
// and m_tvalid rises once the result register holds its word.
// Reset: clears both pipeline valids and all decoder state; max_body_size
// returns to 1 MiB. The block is ready as soon as reset is released.
// Stall: when m_tready is low the result register holds, the input
// register still fills, then s_tready drops until the result is taken.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int SIZE_BITS  = chb_pkg::SIZE_BITS_DEF,
    parameter int COUNT_BITS = chb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [chb_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]                    s_tuser,   // [0] message_start
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] payload_byte, [10:8] status, [42:11] data_total, [47:43] zero
    output logic [chb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                         m_tuser,   // [0] payload_valid
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [chb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int PACK_W = chb_pkg::BYTE_W + chb_pkg::STATUS_W + chb_pkg::TOTAL_W;

    // Input register
    logic                          in_vld_reg;
    logic [chb_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_start_reg;

    // Decoder state
    chb_pkg::phase_t               phase_reg;
    chb_pkg::phase_t               phase_next;
    logic [SIZE_BITS-1:0]          chunk_size_acc_reg;
    logic [SIZE_BITS-1:0]          chunk_size_acc_next;
    logic [SIZE_BITS-1:0]          data_left_reg;
    logic [SIZE_BITS-1:0]          data_left_next;
    logic [COUNT_BITS-1:0]         wire_count_reg;
    logic [COUNT_BITS-1:0]         wire_count_next;
    logic [COUNT_BITS-1:0]         payload_total_reg;
    logic [COUNT_BITS-1:0]         payload_total_next;
    chb_pkg::status_t              status_reg;
    chb_pkg::status_t              status_next;

    logic [chb_pkg::CFG_W-1:0]     max_body_size_reg;

    // Result register
    logic                          out_vld_reg;
    chb_pkg::result_t              out_res_reg;
    chb_pkg::result_t              step_res;

    logic                          advance;

    // The input stage moves into the result stage when the result slot is
    // free or is being emptied this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    chb_step #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .data_byte           (in_byte_reg),
        .message_start       (in_start_reg),
        .max_body_size       (max_body_size_reg),
        .phase               (phase_reg),
        .chunk_size_acc      (chunk_size_acc_reg),
        .data_left           (data_left_reg),
        .wire_count          (wire_count_reg),
        .payload_total       (payload_total_reg),
        .status              (status_reg),
        .phase_next          (phase_next),
        .chunk_size_acc_next (chunk_size_acc_next),
        .data_left_next      (data_left_next),
        .wire_count_next     (wire_count_next),
        .payload_total_next  (payload_total_next),
        .status_next         (status_next),
        .result              (step_res)
    );

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_size_reg <= chb_pkg::MAX_BODY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_body_size_reg <= cfg_data;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    // Decoder state updates once per byte moved to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= chb_pkg::PH_SIZE_FIRST;
            chunk_size_acc_reg <= '0;
            data_left_reg      <= '0;
            wire_count_reg     <= '0;
            payload_total_reg  <= '0;
            status_reg         <= chb_pkg::ST_BUSY;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            chunk_size_acc_reg <= chunk_size_acc_next;
            data_left_reg      <= data_left_next;
            wire_count_reg     <= wire_count_next;
            payload_total_reg  <= payload_total_next;
            status_reg         <= status_next;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tuser[0] = out_res_reg.payload_valid;
    assign m_tdata    = {{(chb_pkg::M_TDATA_W - PACK_W){1'b0}},
                         out_res_reg.data_total,
                         out_res_reg.status,
                         out_res_reg.payload_byte};

    // An error code stays put until a new body starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_start_reg &&
         (status_reg == chb_pkg::ST_BAD || status_reg == chb_pkg::ST_BIG ||
          status_reg == chb_pkg::ST_AFTER))
        |=> $stable(status_reg))
        else $error("sticky error status changed");

    // Payload only flows while the body is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_res_reg.payload_valid) |-> (out_res_reg.status == chb_pkg::ST_BUSY))
        else $error("payload byte with non-busy status");

    // An empty result slot never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
